// ===== hw/rtl/ndw_pkg.sv =====
// ----------------------------------------------------------------------------
// ndw_pkg
// Shared sizes, register codes and inter-module types of the sliding-window
// nucleotide diversity core.
// ----------------------------------------------------------------------------
package ndw_pkg;

	localparam int MAX_HAPLOTYPES = 1024;
	localparam int MAX_WINDOW     = 1024;
	localparam int ALPHABET_SIZE  = 256;

	localparam int BASE_W  = 8;
	localparam int POS_W   = 32;
	localparam int PI_W    = 32;
	localparam int HAP_W   = $clog2(MAX_HAPLOTYPES + 1);
	localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
	localparam int CLASS_W = $clog2(ALPHABET_SIZE);
	localparam int RING_AW = $clog2(MAX_WINDOW);
	localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
	localparam longint MAX_PAIRS = longint'(MAX_HAPLOTYPES) * (MAX_HAPLOTYPES - 1) / 2;
	localparam int MIS_W   = $clog2(MAX_PAIRS + 1);
	localparam int SUM_W   = $clog2(MAX_PAIRS * MAX_WINDOW + 1);
	localparam int NN_W    = $clog2(longint'(MAX_HAPLOTYPES) * MAX_HAPLOTYPES + 1);
	localparam int DEN_W   =
		$clog2(longint'(MAX_HAPLOTYPES) * MAX_HAPLOTYPES * MAX_WINDOW + 1);

	localparam logic [PI_W-1:0] PI_LIMIT = {1'b1, {(PI_W-1){1'b0}}};

	localparam logic [WIN_W-1:0] DEFAULT_WINDOW = WIN_W'(20);
	localparam logic [HAP_W-1:0] DEFAULT_HAPS   = HAP_W'(2);
	localparam logic             DEFAULT_GAP    = 1'b1;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_WINDOW = 2'd0,
		REG_HAPS   = 2'd1,
		REG_GAP    = 2'd2
	} cfg_reg_t;

	// clamped configuration as seen by the datapath
	typedef struct packed {
		logic [WIN_W-1:0] w;
		logic [HAP_W-1:0] n;
		logic             gap;
	} cfg_t;

	// column close / restart handoff from the column counter
	typedef struct packed {
		logic             valid;
		logic             restart;
		logic [MIS_W-1:0] mismatch;
	} close_t;

endpackage

// ===== hw/rtl/ndw_if.sv =====
// ----------------------------------------------------------------------------
// ndw_if
// Valid/ready channels of the core: base beats in, window results out.
// ----------------------------------------------------------------------------
interface ndw_base_if;
	import ndw_pkg::*;

	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] base_char;
	logic              column_end;
	logic              new_alignment;

	modport source (output valid, base_char, column_end, new_alignment, input ready);
	modport sink (input valid, base_char, column_end, new_alignment, output ready);
endinterface

interface ndw_window_if;
	import ndw_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] window_start;
	logic [POS_W-1:0] window_end;
	logic [PI_W-1:0]  pi_fraction;

	modport source (output valid, window_start, window_end, pi_fraction, input ready);
	modport sink (input valid, window_start, window_end, pi_fraction, output ready);
endinterface

// ===== hw/rtl/nucleotide_diversity_window_core.sv =====
// ----------------------------------------------------------------------------
// nucleotide_diversity_window_core
// Bases stream in at one per cycle through the class count read-modify-write.
// After its column_end beat a result passes the window sum, the 32-step divider and the output register.
// Column_end and new_alignment beats wait while the previous column is closing.
// Reset loads W=20, n=2, gap wildcard on; memories are not cleared.
// ----------------------------------------------------------------------------
module nucleotide_diversity_window_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ndw_pkg::PADDR_W-1:0] paddr,
	input  logic [ndw_pkg::PDATA_W-1:0] pwdata,
	output logic [ndw_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	ndw_base_if.sink                    bases,
	ndw_window_if.source                windows
);
	import ndw_pkg::*;

	logic [WIN_W-1:0] wlen_q;
	logic [HAP_W-1:0] haps_q;
	logic             gap_q;

	cfg_reg_t reg_sel;
	logic     cfg_wr;
	logic     cfg_restart;
	cfg_t     cfg;
	close_t   close;
	logic     win_busy;
	logic     take_beat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= DEFAULT_WINDOW;
			haps_q <= DEFAULT_HAPS;
			gap_q  <= DEFAULT_GAP;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_WINDOW: wlen_q <= pwdata[WIN_W-1:0];
				REG_HAPS:   haps_q <= pwdata[HAP_W-1:0];
				REG_GAP:    gap_q  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WINDOW: prdata = PDATA_W'(wlen_q);
			REG_HAPS:   prdata = PDATA_W'(haps_q);
			REG_GAP:    prdata = PDATA_W'(gap_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg_restart = cfg_wr && (reg_sel == REG_WINDOW);

	assign cfg.w = (wlen_q == '0) ? WIN_W'(1) :
		(wlen_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : wlen_q;
	assign cfg.n = (haps_q < HAP_W'(2)) ? HAP_W'(2) :
		(haps_q > HAP_W'(MAX_HAPLOTYPES)) ? HAP_W'(MAX_HAPLOTYPES) : haps_q;
	assign cfg.gap = gap_q;

	// a column close or restart waits until the window stage is free
	assign bases.ready = !((win_busy || close.valid) &&
		(bases.column_end || bases.new_alignment));
	assign take_beat   = bases.valid && bases.ready;

	ndw_column u_column (
		.clk           (clk),
		.arst_n        (arst_n),
		.gap_wild      (cfg.gap),
		.take_beat     (take_beat),
		.base_char     (bases.base_char),
		.column_end    (bases.column_end),
		.new_alignment (bases.new_alignment),
		.close         (close)
	);

	ndw_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cfg_restart (cfg_restart),
		.close       (close),
		.busy        (win_busy),
		.win         (windows)
	);

endmodule

// ===== hw/rtl/ndw_column.sv =====
// ----------------------------------------------------------------------------
// ndw_column
// Per-column mismatch counter: class count memory with read-modify-write,
// forwarding of the last write, seen bits cleared at each column end.
// ----------------------------------------------------------------------------
module ndw_column (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       gap_wild,
	input  logic                       take_beat,
	input  logic [ndw_pkg::BASE_W-1:0] base_char,
	input  logic                       column_end,
	input  logic                       new_alignment,
	output ndw_pkg::close_t            close
);
	import ndw_pkg::*;

	localparam logic [BASE_W-1:0] CHAR_LOW_A = 8'h61;
	localparam logic [BASE_W-1:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [BASE_W-1:0] CASE_DIFF  = 8'h20;
	localparam logic [BASE_W-1:0] CHAR_WILD  = 8'h4E;
	localparam logic [BASE_W-1:0] CHAR_GAP   = 8'h2D;

	logic [HAP_W-1:0] count_mem [ALPHABET_SIZE];

	logic [BASE_W-1:0]  upper_s0;
	logic               wild_s0;
	logic [CLASS_W-1:0] k_s0;

	logic               valid_s1;
	logic               wild_s1;
	logic               end_s1;
	logic               newaln_s1;
	logic [CLASS_W-1:0] k_s1;
	logic [HAP_W-1:0]   cnt_rd_s1;

	logic [ALPHABET_SIZE-1:0] seen_q;
	logic [HAP_W-1:0]         nonwild_q;
	logic [MIS_W-1:0]         mismatch_q;
	logic                     fwd_vld_q;
	logic [CLASS_W-1:0]       fwd_k_q;
	logic [HAP_W-1:0]         fwd_cnt_q;

	logic             seen_bit;
	logic [HAP_W-1:0] nonwild_cur;
	logic [MIS_W-1:0] mismatch_cur;
	logic [HAP_W-1:0] old_cnt;
	logic [HAP_W-1:0] ck;
	logic             take;
	logic [HAP_W-1:0] pair_diff;
	logic [MIS_W-1:0] mismatch_next;
	logic [HAP_W-1:0] nonwild_next;
	logic [HAP_W-1:0] cnt_wdata;

	assign upper_s0 = (base_char >= CHAR_LOW_A && base_char <= CHAR_LOW_Z) ?
		base_char - CASE_DIFF : base_char;
	assign wild_s0  = (upper_s0 == CHAR_WILD) || (gap_wild && base_char == CHAR_GAP);
	assign k_s0     = upper_s0[CLASS_W-1:0];

	always_ff @(posedge clk) begin
		if (take) begin
			count_mem[k_s1] <= cnt_wdata;
		end
		cnt_rd_s1 <= count_mem[k_s0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (take_beat) begin
			wild_s1   <= wild_s0;
			end_s1    <= column_end;
			newaln_s1 <= new_alignment;
			k_s1      <= k_s0;
		end
	end

	// a new alignment drops the partial column before its own base counts
	assign seen_bit     = newaln_s1 ? 1'b0 : seen_q[k_s1];
	assign nonwild_cur  = newaln_s1 ? '0 : nonwild_q;
	assign mismatch_cur = newaln_s1 ? '0 : mismatch_q;

	// memory read was issued before the previous beat's write landed
	assign old_cnt   = (fwd_vld_q && fwd_k_q == k_s1) ? fwd_cnt_q : cnt_rd_s1;
	assign ck        = seen_bit ? old_cnt : '0;
	assign take      = valid_s1 && !wild_s1 && (nonwild_cur < HAP_W'(MAX_HAPLOTYPES));
	assign pair_diff = nonwild_cur - ck;
	assign cnt_wdata = ck + HAP_W'(1);

	assign mismatch_next = take ? mismatch_cur + MIS_W'(pair_diff) : mismatch_cur;
	assign nonwild_next  = take ? nonwild_cur + HAP_W'(1) : nonwild_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			nonwild_q  <= '0;
			mismatch_q <= '0;
			fwd_vld_q  <= 1'b0;
		end else begin
			fwd_vld_q <= take;
			if (valid_s1) begin
				if (end_s1) begin
					seen_q     <= '0;
					nonwild_q  <= '0;
					mismatch_q <= '0;
				end else begin
					nonwild_q  <= nonwild_next;
					mismatch_q <= mismatch_next;
					if (newaln_s1) begin
						seen_q <= take ?
							({{(ALPHABET_SIZE-1){1'b0}}, 1'b1} << k_s1) : '0;
					end else if (take) begin
						seen_q[k_s1] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fwd_k_q   <= k_s1;
			fwd_cnt_q <= cnt_wdata;
		end
	end

	assign close.valid    = valid_s1 && end_s1;
	assign close.restart  = valid_s1 && newaln_s1;
	assign close.mismatch = mismatch_next;

	a_nonwild_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nonwild_q <= HAP_W'(MAX_HAPLOTYPES))
		else $error("column base count beyond limit");

endmodule

// ===== hw/rtl/ndw_div.sv =====
// ----------------------------------------------------------------------------
// ndw_div
// Restoring fraction divider, one quotient bit per cycle:
// floor(num * 2^32 / den), saturated at one half.
// ----------------------------------------------------------------------------
module ndw_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ndw_pkg::SUM_W-1:0] num,
	input  logic [ndw_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [ndw_pkg::PI_W-1:0]  quotient
);
	import ndw_pkg::*;

	localparam int CNT_W = $clog2(PI_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [PI_W-1:0]  quo_q;
	logic             sat_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_sub;
	logic             sat_in;

	assign rem_sh  = {rem_q, 1'b0};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign sat_in  = DEN_W'(num) >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(PI_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= den;
			sat_q <= sat_in;
			rem_q <= sat_in ? '0 : DEN_W'(num);
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[PI_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = (sat_q || quo_q > PI_LIMIT) ? PI_LIMIT : quo_q;

endmodule

// ===== hw/rtl/ndw_window.sv =====
// ----------------------------------------------------------------------------
// ndw_window
// Window stage: mismatch ring memory, running window sum, denominator
// pipeline, divider control and the result output register.
// ----------------------------------------------------------------------------
module ndw_window (
	input  logic            clk,
	input  logic            arst_n,
	input  ndw_pkg::cfg_t   cfg,
	input  logic            cfg_restart,
	input  ndw_pkg::close_t close,
	output logic            busy,
	ndw_window_if.source    win
);
	import ndw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} fin_state_t;

	logic [MIS_W-1:0] ring_mem [MAX_WINDOW];

	fin_state_t       state_q;
	logic [SUM_W-1:0] sum_q;
	logic [POS_W-1:0] idx_q;
	logic [RING_AW-1:0] pos_q;
	logic [FILL_W-1:0] fill_q;
	logic [MIS_W-1:0] cm_q;
	logic [MIS_W-1:0] ring_rd_q;
	logic [POS_W-1:0] start_q;
	logic [POS_W-1:0] end_q;
	logic [NN_W-1:0]  nn_q;
	logic [DEN_W-1:0] den_q;
	logic             out_valid_q;
	logic [POS_W-1:0] out_start_q;
	logic [POS_W-1:0] out_end_q;
	logic [PI_W-1:0]  out_pi_q;

	logic [2*HAP_W-1:0]      nn_full;
	logic [NN_W+WIN_W-1:0]   den_full;
	logic [RING_AW-1:0]      rd_addr;
	logic [MIS_W-1:0]        old_cnt;
	logic [SUM_W-1:0]        sum_next;
	logic [FILL_W-1:0]       fill_next;
	logic [POS_W-1:0]        idx_next;
	logic                    emit;
	logic                    ring_we;
	logic                    div_start;
	logic                    div_done;
	logic [PI_W-1:0]         div_quo;
	logic                    load_out;
	logic                    restart;

	// n*n*W, two registered products
	assign nn_full  = cfg.n * cfg.n;
	assign den_full = nn_q * cfg.w;

	always_ff @(posedge clk) begin
		nn_q  <= nn_full[NN_W-1:0];
		den_q <= den_full[DEN_W-1:0];
	end

	// slot leaving the window; unused until the ring holds W columns
	assign rd_addr = pos_q - cfg.w[RING_AW-1:0];
	assign ring_we = (state_q == ST_SUM);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[pos_q] <= cm_q;
		end
		ring_rd_q <= ring_mem[rd_addr];
	end

	assign old_cnt   = (fill_q >= FILL_W'(cfg.w)) ? ring_rd_q : '0;
	assign sum_next  = sum_q + SUM_W'(cm_q) - SUM_W'(old_cnt);
	assign fill_next = (fill_q < FILL_W'(MAX_WINDOW)) ? fill_q + FILL_W'(1) : fill_q;
	assign idx_next  = idx_q + POS_W'(1);
	assign emit      = fill_next >= FILL_W'(cfg.w);
	assign div_start = (state_q == ST_SUM) && emit;
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || win.ready);
	assign restart   = cfg_restart || close.restart;

	ndw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (sum_next),
		.den      (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
		end else begin
			if (restart) begin
				sum_q  <= '0;
				idx_q  <= '0;
				pos_q  <= '0;
				fill_q <= '0;
			end else if (state_q == ST_SUM) begin
				sum_q  <= sum_next;
				idx_q  <= idx_next;
				pos_q  <= pos_q + RING_AW'(1);
				fill_q <= fill_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (close.valid) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= emit ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && close.valid) begin
			cm_q <= close.mismatch;
		end
		if (state_q == ST_SUM) begin
			end_q   <= idx_next;
			start_q <= idx_next - POS_W'(cfg.w) + POS_W'(1);
		end
		if (load_out) begin
			out_start_q <= start_q;
			out_end_q   <= end_q;
			out_pi_q    <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (win.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign busy             = (state_q != ST_IDLE);
	assign win.valid        = out_valid_q;
	assign win.window_start = out_start_q;
	assign win.window_end   = out_end_q;
	assign win.pi_fraction  = out_pi_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_WINDOW))
		else $error("ring fill beyond ring size");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> sum_q == '0)
		else $error("window sum nonzero with empty ring");

	a_pos_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FILL_W'(MAX_WINDOW) |-> pos_q == fill_q[RING_AW-1:0])
		else $error("ring write slot out of step with fill");

endmodule
